FILE: src/tts_pkg.sv
// tts_pkg: shared types and constants for the character-cell terminal
// field widths, operation codes and the command flags passed between modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 70;
    localparam int DEF_ROWS    = 30;

    // beat field widths
    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int INDEX_W = 12;

    // character that moves to the start of the next line
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT     = 3'd0,
        OP_BACK    = 3'd1,
        OP_SET_CUR = 3'd2,
        OP_SET_ROW = 3'd3,
        OP_SET_COL = 3'd4,
        OP_CLEAR   = 3'd5,
        OP_READ    = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    // effects of one accepted item, from the cursor unit to the sequencer
    typedef struct packed {
        logic wr_en;       // one cell write at the item
        logic rd_en;       // cell read, result follows the read data
        logic rd_hit;      // read index lies inside the screen
        logic sweep_start; // zero a run of cells after the item
    } tts_cmd_t;

endpackage

`default_nettype wire

FILE: src/text_terminal_cursor_scroll.sv
// text_terminal_cursor_scroll: character-cell terminal with cursor and scroll
// instantiates tts_cursor and tts_screen_mem; depends on tts_pkg
//
// Usage: an input beat (op, char_code, row, col, cell_index) is taken when
// in_valid is high and in_stall low; each beat returns exactly one result
// beat (cursor_row_out, cursor_col_out, cell_value), taken when out_valid is
// high and out_stall low. The result sits in an output register.
// Every op but read cell has its result registered in the cycle after it
// is taken; read cell passes through ST_READ (one memory read) first. A new
// beat can be taken in the cycle after one that is no read and leaves no
// sweep, if the result is not stalled, so throughput is one item per cycle.
// The screen is a ring of rows over one single-port-write memory: a scroll
// moves the ring base and zeroes the old top row, during which no input is
// taken; clear screen zeroes every cell. After reset the same clearing pass
// runs before the first beat is taken; the cursor starts at row 0, column 0.
// A stalled result holds; while it is stalled no new beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module text_terminal_cursor_scroll #(
    parameter int COLUMNS = tts_pkg::DEF_COLUMNS,
    parameter int ROWS    = tts_pkg::DEF_ROWS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tts_pkg::OP_W-1:0]      op,
    input  wire logic [tts_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tts_pkg::ROW_W-1:0]     row,
    input  wire logic [tts_pkg::COL_W-1:0]     col,
    input  wire logic [tts_pkg::INDEX_W-1:0]   cell_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [tts_pkg::ROW_W-1:0]     cursor_row_out,
    output logic      [tts_pkg::COL_W-1:0]     cursor_col_out,
    output logic      [tts_pkg::CHAR_W-1:0]    cell_value
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]              sweep_last_reg, sweep_last_next;
    logic                       rd_hit_reg, rd_hit_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tts_pkg::ROW_W-1:0]  out_row_reg, out_row_next;
    logic [tts_pkg::COL_W-1:0]  out_col_reg, out_col_next;
    logic [tts_pkg::CHAR_W-1:0] out_cell_reg, out_cell_next;

    logic                       accept;
    logic                       out_take;
    tts_pkg::tts_cmd_t          cmd;
    logic [AW-1:0]              cur_wr_addr;
    logic [tts_pkg::CHAR_W-1:0] cur_wr_data;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              sweep_first;
    logic [AW-1:0]              sweep_last;
    logic [tts_pkg::ROW_W-1:0]  row_next;
    logic [tts_pkg::COL_W-1:0]  col_next;
    logic                       mem_wr_en;
    logic [AW-1:0]              mem_wr_addr;
    logic [tts_pkg::CHAR_W-1:0] mem_wr_data;
    logic [tts_pkg::CHAR_W-1:0] mem_rd_data;

    // handshake
    assign out_take = out_valid_reg & ~out_stall;
    assign in_stall = ~((state_reg == ST_IDLE) & (~out_valid_reg | ~out_stall));
    assign accept   = in_valid & ~in_stall;

    tts_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .char_code   (char_code),
        .row_in      (row),
        .col_in      (col),
        .cell_index  (cell_index),
        .cmd         (cmd),
        .wr_addr     (cur_wr_addr),
        .wr_data     (cur_wr_data),
        .rd_addr     (rd_addr),
        .sweep_first (sweep_first),
        .sweep_last  (sweep_last),
        .row_next    (row_next),
        .col_next    (col_next)
    );

    // write port: zeroing sweep or the cell write of an accepted beat
    assign mem_wr_en   = (state_reg == ST_SWEEP) | (accept & cmd.wr_en);
    assign mem_wr_addr = (state_reg == ST_SWEEP) ? sweep_addr_reg : cur_wr_addr;
    assign mem_wr_data = (state_reg == ST_SWEEP) ? '0 : cur_wr_data;

    tts_screen_mem #(
        .DEPTH (CELLS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept & cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    // sequencer and result register
    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        rd_hit_next     = rd_hit_reg;
        out_valid_next  = out_valid_reg & ~out_take;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_cell_next   = out_cell_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_row_next  = row_next;
                    out_col_next  = col_next;
                    out_cell_next = '0;
                    if (cmd.rd_en)
                    begin
                        state_next  = ST_READ;
                        rd_hit_next = cmd.rd_hit;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        if (cmd.sweep_start)
                        begin
                            state_next      = ST_SWEEP;
                            sweep_addr_next = sweep_first;
                            sweep_last_next = sweep_last;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                out_cell_next  = rd_hit_reg ? mem_rd_data : '0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_last_reg <= AW'(CELLS - 1);
            rd_hit_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_cell_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            rd_hit_reg     <= rd_hit_next;
            out_valid_reg  <= out_valid_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            out_cell_reg   <= out_cell_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_row_out = out_row_reg;
    assign cursor_col_out = out_col_reg;
    assign cell_value     = out_cell_reg;

    // a read beat passes through ST_READ before it reaches the result register
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op == tts_pkg::OP_READ) |=> (state_reg == ST_READ) ##1 out_valid)
        else $error("read beat did not produce a result");

    // every other beat has its result on the next edge
    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (op != tts_pkg::OP_READ) |=> out_valid)
        else $error("missing result after beat");

    // zeroing sweep never runs past its end
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (sweep_addr_reg <= sweep_last_reg))
        else $error("sweep address beyond end of run");

    // cursor in the result lies on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(cursor_row_out) < ROWS) && (int'(cursor_col_out) < COLUMNS))
        else $error("cursor outside the screen");

endmodule

`default_nettype wire

FILE: src/tts_screen_mem.sv
// tts_screen_mem: screen store, one write port and one registered read port
// depends on tts_pkg for the cell width and the default depth
`timescale 1ns / 1ps
`default_nettype none

module tts_screen_mem #(
    parameter int DEPTH = tts_pkg::DEF_COLUMNS * tts_pkg::DEF_ROWS
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [tts_pkg::CHAR_W-1:0]    wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic      [tts_pkg::CHAR_W-1:0]    rd_data
);

    logic [tts_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [tts_pkg::CHAR_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered, loaded only while rd_en is high
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/tts_cursor.sv
// tts_cursor: cursor and scroll base registers, item decode and address mapping
// the screen is kept as a ring of rows; base_reg is the cell address of row 0
// depends on tts_pkg
`timescale 1ns / 1ps
`default_nettype none

module tts_cursor #(
    parameter int COLUMNS = tts_pkg::DEF_COLUMNS,
    parameter int ROWS    = tts_pkg::DEF_ROWS,
    localparam int CELLS  = COLUMNS * ROWS,
    localparam int AW     = $clog2(CELLS)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [tts_pkg::OP_W-1:0]     op,
    input  wire logic [tts_pkg::CHAR_W-1:0]   char_code,
    input  wire logic [tts_pkg::ROW_W-1:0]    row_in,
    input  wire logic [tts_pkg::COL_W-1:0]    col_in,
    input  wire logic [tts_pkg::INDEX_W-1:0]  cell_index,
    output tts_pkg::tts_cmd_t                 cmd,
    output logic      [AW-1:0]                wr_addr,
    output logic      [tts_pkg::CHAR_W-1:0]   wr_data,
    output logic      [AW-1:0]                rd_addr,
    output logic      [AW-1:0]                sweep_first,
    output logic      [AW-1:0]                sweep_last,
    output logic      [tts_pkg::ROW_W-1:0]    row_next,
    output logic      [tts_pkg::COL_W-1:0]    col_next
);

    localparam int XW = (AW > tts_pkg::INDEX_W) ? AW : tts_pkg::INDEX_W;

    logic [tts_pkg::ROW_W-1:0] row_reg;
    logic [tts_pkg::COL_W-1:0] col_reg;
    logic [AW-1:0]             index_reg;
    logic [AW-1:0]             base_reg;

    logic [AW-1:0]             index_next;
    logic [AW-1:0]             base_next;
    logic [AW-1:0]             wr_log;
    logic [AW:0]               wr_sum;
    logic [AW:0]               rd_sum;
    logic [AW:0]               base_sum;
    logic [XW-1:0]             idx_ext;
    logic [tts_pkg::ROW_W-1:0] row_clamp;
    logic [tts_pkg::COL_W-1:0] col_clamp;
    logic                      newline;
    logic                      scroll;
    logic                      clear;

    // saturate requested coordinates to the screen
    assign row_clamp = (int'(row_in) >= ROWS) ? tts_pkg::ROW_W'(ROWS - 1) : row_in;
    assign col_clamp = (int'(col_in) >= COLUMNS) ? tts_pkg::COL_W'(COLUMNS - 1) : col_in;

    // item decode and next cursor
    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        newline      = 1'b0;
        scroll       = 1'b0;
        clear        = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        wr_data      = char_code;
        wr_log       = index_reg;
        case (op)
            tts_pkg::OP_PUT:
            begin
                if (char_code == tts_pkg::NEWLINE_CODE)
                begin
                    newline = 1'b1;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    if (int'(col_reg) >= COLUMNS - 1)
                    begin
                        newline = 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + tts_pkg::COL_W'(1);
                    end
                end
            end
            tts_pkg::OP_BACK:
            begin
                cmd.wr_en = 1'b1;
                wr_data   = '0;
                if (col_reg != '0)
                begin
                    col_next = col_reg - tts_pkg::COL_W'(1);
                    wr_log   = index_reg - AW'(1);
                end
            end
            tts_pkg::OP_SET_CUR:
            begin
                row_next = row_clamp;
                col_next = col_clamp;
            end
            tts_pkg::OP_SET_ROW:
            begin
                row_next = row_clamp;
            end
            tts_pkg::OP_SET_COL:
            begin
                col_next = col_clamp;
            end
            tts_pkg::OP_CLEAR:
            begin
                row_next = '0;
                col_next = '0;
                clear    = 1'b1;
            end
            tts_pkg::OP_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            default:
            begin
            end
        endcase

        // newline: next row, or scroll on the last row
        if (newline)
        begin
            col_next = '0;
            if (int'(row_reg) >= ROWS - 1)
            begin
                scroll   = 1'b1;
                row_next = tts_pkg::ROW_W'(ROWS - 1);
            end
            else
            begin
                row_next = row_reg + tts_pkg::ROW_W'(1);
            end
        end

        // read range check and zeroing run request
        cmd.rd_hit      = idx_ext < XW'(CELLS);
        cmd.sweep_start = scroll | clear;
    end

    // linear cursor index
    assign index_next = AW'(AW'(row_next) * AW'(COLUMNS)) + AW'(col_next);

    // scroll advances the ring by one row; clear resets the ring base to zero
    assign base_sum  = {1'b0, base_reg} + (AW + 1)'(COLUMNS);
    assign base_next = clear ? '0 :
                       !scroll ? base_reg :
                       (base_sum == (AW + 1)'(CELLS)) ? '0 : base_sum[AW-1:0];

    // logical to physical cell address
    assign wr_sum  = {1'b0, wr_log} + {1'b0, base_reg};
    assign wr_addr = (wr_sum >= (AW + 1)'(CELLS)) ? AW'(wr_sum - (AW + 1)'(CELLS))
                                                  : wr_sum[AW-1:0];

    assign idx_ext    = XW'(cell_index);
    assign rd_sum     = {1'b0, idx_ext[AW-1:0]} + {1'b0, base_reg};
    assign rd_addr    = (rd_sum >= (AW + 1)'(CELLS)) ? AW'(rd_sum - (AW + 1)'(CELLS))
                                                     : rd_sum[AW-1:0];

    // zeroing run: old top row on scroll, whole store on clear
    assign sweep_first     = clear ? '0 : base_reg;
    assign sweep_last      = clear ? AW'(CELLS - 1) : base_reg + AW'(COLUMNS - 1);

    // cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            index_reg <= '0;
            base_reg  <= '0;
        end
        else if (accept)
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            index_reg <= index_next;
            base_reg  <= base_next;
        end
    end

endmodule

`default_nettype wire
